[hdl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console cell writer
// Screen geometry limits, opcodes, sequencer states and the datapath
// control bundle passed from the sequencer to the screen memory.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int MaxCols   = 128;
	localparam int MaxRows   = 32;
	localparam int TabStep   = 4;
	localparam int CellCount = MaxCols * MaxRows;
	localparam int AddrW     = $clog2(CellCount);
	localparam int ColW      = 7;
	localparam int RowW      = 5;

	localparam logic [7:0] BlankChar = 8'h20;
	localparam logic [7:0] ResetAttr = 8'h07;
	localparam logic [7:0] ResetCols = 8'd80;
	localparam logic [5:0] ResetRows = 6'd25;

	typedef enum logic [2:0] {
		OP_PUT_CHAR     = 3'd0,
		OP_SET_POS      = 3'd1,
		OP_SET_ATTR     = 3'd2,
		OP_SET_DEFAULT  = 3'd3,
		OP_RESTORE_DEF  = 3'd4,
		OP_CLEAR        = 3'd5,
		OP_READ_CELL    = 3'd6,
		OP_NONE         = 3'd7
	} opcode_t;

	typedef enum logic [3:0] {
		ST_INIT,      // clear sweep after reset
		ST_IDLE,
		ST_DECODE,    // work out the put_char move
		ST_MUL,       // row * cols through the shared multiplier
		ST_WRITE,     // write the printable cell
		ST_SCROLL_RD, // read cell i + cols
		ST_SCROLL_WR, // write it to cell i
		ST_BLANK,     // blank the bottom row
		ST_FILL,      // clear the visible area
		ST_READ,      // issue read_cell
		ST_READ_WAIT,
		ST_LIN,       // cursor linear position
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		logic [15:0]      wr_data;
		logic             rd_en;
		logic [AddrW-1:0] rd_addr;
	} mem_ctrl_t;

	localparam int RegCols = 0;
	localparam int RegRows = 1;

endpackage

[hdl/tcw_screen_ram.sv]
// ----------------------------------------------------------------------------
// tcw_screen_ram: screen cell store
// One write port and one registered read port over all cells.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
	input  logic                   clk,
	input  tcw_pkg::mem_ctrl_t     ctrl,
	output logic [15:0]            rd_data
);

	logic [15:0] mem [tcw_pkg::CellCount];

	// write port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data <= mem[ctrl.rd_addr];
		end
	end

endmodule

[hdl/tcw_mult.sv]
// ----------------------------------------------------------------------------
// tcw_mult: shared row by column multiplier
// Registered product of a row index and the column count.
// ----------------------------------------------------------------------------
module tcw_mult (
	input  logic                     clk,
	input  logic [5:0]               row,
	input  logic [7:0]               cols,
	output logic [13:0]              prod_q
);

	// hold the product for the next step
	always_ff @(posedge clk) begin
		prod_q <= 14'(row) * 14'(cols);
	end

endmodule

[hdl/text_console_cell_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit: text-mode console engine
// Keeps a screen of attribute/character cells, a cursor and two
// attributes; each command transfer gives one status transfer.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         command: opcode, char, attribute, x, y
//  m_axis    out        cursor column, row, linear position, attribute, cell
//  apb       in/out     screen_cols at 0x0, screen_rows at 0x4
//
// A plain command passes the linear-position and done states; put_char
// adds decode and the scroll check, a printable put_char also the cell
// write; read_cell goes via the multiplier, read and read-wait states.
// A scroll copies each row up and blanks the bottom row; clear writes
// every visible cell. After reset a sweep over all 4096 cells blanks the
// screen; no command is taken meanwhile. The status register is held until
// taken; a new command is accepted only once the previous status has gone.
// After a geometry write commands are held off while an off-screen cursor is pulled in.
module text_console_cell_writer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] opcode, [10:3] char_code, [18:11] attr_value,
	// [26:19] pos_x, [34:27] pos_y, zero fill to 40 bits
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [6:0] cursor_col, [11:7] cursor_row, [23:12] cursor_linear,
	// [31:24] current_attr, [47:32] cell_word
	output logic [47:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = tcw_pkg::AddrW;

	tcw_pkg::state_t state_q, state_d;
	tcw_pkg::mem_ctrl_t mctl;

	logic [7:0]  cols_reg_q;
	logic [5:0]  rows_reg_q;
	logic [6:0]  col_q;
	logic [4:0]  row_q;
	logic [7:0]  attr_q, def_q;
	logic [2:0]  op_q;
	logic [7:0]  ch_q, av_q;
	logic [6:0]  px_q;
	logic [4:0]  py_q;
	logic [AW:0] idx_q;
	logic [AW:0] end_q;
	logic [15:0] cell_q;
	logic        out_valid_q;
	logic [47:0] out_q;
	logic        scroll_q;
	logic [15:0] rd_data;
	logic [13:0] prod_q;
	logic [5:0]  mul_row;

	// effective geometry
	logic [7:0] ecols;
	logic [5:0] erows;
	always_comb begin
		ecols = (cols_reg_q == 8'd0) ? 8'd1 :
			(cols_reg_q > 8'(tcw_pkg::MaxCols)) ? 8'(tcw_pkg::MaxCols) : cols_reg_q;
		erows = (rows_reg_q == 6'd0) ? 6'd1 :
			(rows_reg_q > 6'(tcw_pkg::MaxRows)) ? 6'(tcw_pkg::MaxRows) : rows_reg_q;
	end
	logic [6:0] cmax;
	logic [4:0] rmax;
	assign cmax = 7'(ecols - 8'd1);
	assign rmax = 5'(erows - 6'd1);

	// saturated input coordinates
	logic [7:0] in_x, in_y;
	logic [6:0] sat_x;
	logic [4:0] sat_y;
	assign in_x  = s_axis_tdata[26:19];
	assign in_y  = s_axis_tdata[34:27];
	assign sat_x = (in_x > {1'b0, cmax}) ? cmax : in_x[6:0];
	assign sat_y = (in_y > {3'b0, rmax}) ? rmax : in_y[4:0];

	// hold off commands while busy, while a status waits, or until the cursor sits inside the geometry
	logic accept;
	assign s_axis_tready = (state_q == tcw_pkg::ST_IDLE) && !out_valid_q &&
		(col_q <= cmax) && (row_q <= rmax);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	always_comb begin
		unique case (paddr)
			3'd0:    prdata = {24'd0, cols_reg_q};
			3'd4:    prdata = {26'd0, rows_reg_q};
			default: prdata = 32'd0;
		endcase
	end

	// put_char decode on the held cursor
	logic printable, wraps;
	logic [7:0] ncol;
	logic [5:0] nrow;
	always_comb begin
		printable = (ch_q >= 8'h20) && (ch_q != 8'h7F);
		ncol = {1'b0, col_q};
		nrow = {1'b0, row_q};
		if (printable) ncol = {1'b0, col_q} + 8'd1;
		else if (ch_q == 8'h09)
			ncol = 8'((({1'b0, col_q} / 8'(tcw_pkg::TabStep)) + 8'd1) * 8'(tcw_pkg::TabStep));
		else if (ch_q == 8'h08) ncol = (col_q != 7'd0) ? {1'b0, col_q} - 8'd1 : 8'd0;
		else if (ch_q == 8'h0A) begin
			ncol = 8'd0;
			nrow = {1'b0, row_q} + 6'd1;
		end else if (ch_q == 8'h0D) ncol = 8'd0;
		wraps = ncol >= ecols;
	end

	assign mul_row = (state_q == tcw_pkg::ST_DECODE) ? {1'b0, row_q} :
		(state_q == tcw_pkg::ST_READ || state_q == tcw_pkg::ST_MUL) ? {1'b0, py_q} :
		{1'b0, row_q};

	tcw_mult u_mult (.clk(clk), .row(mul_row), .cols(ecols), .prod_q(prod_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT:
				if (idx_q == (AW+1)'(tcw_pkg::CellCount - 1)) state_d = tcw_pkg::ST_IDLE;
			tcw_pkg::ST_IDLE:
				if (accept) begin
					unique case (tcw_pkg::opcode_t'(s_axis_tdata[2:0]))
						tcw_pkg::OP_PUT_CHAR:  state_d = tcw_pkg::ST_DECODE;
						tcw_pkg::OP_CLEAR:     state_d = tcw_pkg::ST_FILL;
						tcw_pkg::OP_READ_CELL: state_d = tcw_pkg::ST_MUL;
						default:               state_d = tcw_pkg::ST_LIN;
					endcase
				end
			tcw_pkg::ST_DECODE:
				state_d = printable ? tcw_pkg::ST_WRITE : tcw_pkg::ST_SCROLL_RD;
			tcw_pkg::ST_WRITE:     state_d = tcw_pkg::ST_SCROLL_RD;
			tcw_pkg::ST_SCROLL_RD:
				if (!scroll_q) state_d = tcw_pkg::ST_LIN;
				else if (idx_q + (AW+1)'(ecols) >= end_q) state_d = tcw_pkg::ST_BLANK;
				else state_d = tcw_pkg::ST_SCROLL_WR;
			tcw_pkg::ST_SCROLL_WR: state_d = tcw_pkg::ST_SCROLL_RD;
			tcw_pkg::ST_BLANK:
				if (idx_q + 1'b1 >= end_q) state_d = tcw_pkg::ST_LIN;
			tcw_pkg::ST_FILL:
				if (idx_q + 1'b1 >= end_q) state_d = tcw_pkg::ST_LIN;
			tcw_pkg::ST_MUL:       state_d = tcw_pkg::ST_READ;
			tcw_pkg::ST_READ:      state_d = tcw_pkg::ST_READ_WAIT;
			tcw_pkg::ST_READ_WAIT: state_d = tcw_pkg::ST_LIN;
			tcw_pkg::ST_LIN:       state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_DONE:      state_d = tcw_pkg::ST_IDLE;
			default:               state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		mctl = '0;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				mctl.wr_en   = 1'b1;
				mctl.wr_addr = idx_q[AW-1:0];
				mctl.wr_data = {tcw_pkg::ResetAttr, tcw_pkg::BlankChar};
			end
			tcw_pkg::ST_WRITE: begin
				mctl.wr_en   = 1'b1;
				mctl.wr_addr = AW'(prod_q) + AW'(col_q);
				mctl.wr_data = {attr_q, ch_q};
			end
			tcw_pkg::ST_SCROLL_RD: begin
				mctl.rd_en   = 1'b1;
				mctl.rd_addr = AW'(idx_q + (AW+1)'(ecols));
			end
			tcw_pkg::ST_SCROLL_WR: begin
				mctl.wr_en   = 1'b1;
				mctl.wr_addr = idx_q[AW-1:0];
				mctl.wr_data = rd_data;
			end
			tcw_pkg::ST_BLANK: begin
				mctl.wr_en   = 1'b1;
				mctl.wr_addr = idx_q[AW-1:0];
				mctl.wr_data = {attr_q, tcw_pkg::BlankChar};
			end
			tcw_pkg::ST_FILL: begin
				mctl.wr_en   = 1'b1;
				mctl.wr_addr = idx_q[AW-1:0];
				mctl.wr_data = {av_q, tcw_pkg::BlankChar};
			end
			tcw_pkg::ST_READ: begin
				mctl.rd_en   = 1'b1;
				mctl.rd_addr = AW'(prod_q) + AW'(px_q);
			end
			default: mctl = '0;
		endcase
	end

	tcw_screen_ram u_ram (.clk(clk), .ctrl(mctl), .rd_data(rd_data));

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg_q  <= tcw_pkg::ResetCols;
			rows_reg_q  <= tcw_pkg::ResetRows;
			col_q       <= '0;
			row_q       <= '0;
			attr_q      <= tcw_pkg::ResetAttr;
			def_q       <= tcw_pkg::ResetAttr;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			scroll_q    <= 1'b0;
		end else begin
			// config writes, cursor saturates into new geometry
			if (cfg_wr) begin
				if (paddr == 3'(4 * tcw_pkg::RegCols)) begin
					cols_reg_q <= pwdata[7:0];
				end else if (paddr == 3'(4 * tcw_pkg::RegRows)) begin
					rows_reg_q <= pwdata[5:0];
				end
			end
			if (state_q == tcw_pkg::ST_IDLE && !accept) begin
				if (col_q > cmax) col_q <= cmax;
				if (row_q > rmax) row_q <= rmax;
			end
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				tcw_pkg::ST_INIT: idx_q <= idx_q + 1'b1;
				tcw_pkg::ST_IDLE:
					if (accept) begin
						idx_q <= '0;
						end_q <= (AW+1)'(14'(ecols) * 14'(erows));
						cell_q <= '0;
						unique case (tcw_pkg::opcode_t'(s_axis_tdata[2:0]))
							tcw_pkg::OP_SET_POS: begin
								col_q <= sat_x;
								row_q <= sat_y;
							end
							tcw_pkg::OP_SET_ATTR:    attr_q <= s_axis_tdata[18:11];
							tcw_pkg::OP_SET_DEFAULT: def_q  <= s_axis_tdata[18:11];
							tcw_pkg::OP_RESTORE_DEF: attr_q <= def_q;
							tcw_pkg::OP_CLEAR: begin
								col_q  <= '0;
								row_q  <= '0;
								attr_q <= s_axis_tdata[18:11];
								def_q  <= s_axis_tdata[18:11];
							end
							default: ;
						endcase
					end
				tcw_pkg::ST_DECODE, tcw_pkg::ST_WRITE:
					// commit the move once any printable cell has gone out
					if (state_q == tcw_pkg::ST_WRITE || !printable) begin
						if (wraps) begin
							col_q <= '0;
							if (nrow + 6'd1 >= erows) begin
								row_q    <= rmax;
								scroll_q <= 1'b1;
							end else begin
								row_q    <= row_q + 5'd1;
								scroll_q <= 1'b0;
							end
						end else begin
							col_q <= ncol[6:0];
							if (nrow >= erows) begin
								row_q    <= rmax;
								scroll_q <= 1'b1;
							end else begin
								row_q    <= nrow[4:0];
								scroll_q <= 1'b0;
							end
						end
					end
				tcw_pkg::ST_SCROLL_RD:
					if (scroll_q && idx_q + (AW+1)'(ecols) >= end_q) scroll_q <= 1'b0;
				tcw_pkg::ST_SCROLL_WR: idx_q <= idx_q + 1'b1;
				tcw_pkg::ST_BLANK, tcw_pkg::ST_FILL: idx_q <= idx_q + 1'b1;
				tcw_pkg::ST_READ_WAIT: ;
				tcw_pkg::ST_LIN:
					if (op_q == 3'(tcw_pkg::OP_READ_CELL)) cell_q <= rd_data;
				tcw_pkg::ST_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// command payload hold
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_axis_tdata[2:0];
			ch_q <= s_axis_tdata[10:3];
			av_q <= s_axis_tdata[18:11];
			px_q <= sat_x;
			py_q <= sat_y;
		end
		if (state_q == tcw_pkg::ST_DONE) begin
			out_q <= {cell_q, attr_q, 12'(prod_q) + 12'(col_q), row_q, col_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// status held while stalled on the output
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_q))
		else $error("status changed while stalled");
	// no command taken while a status waits
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !s_axis_tready)
		else $error("command accepted with status pending");
	// cursor stays on screen in the done state
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcw_pkg::ST_DONE |-> col_q <= cmax && row_q <= rmax)
		else $error("cursor off screen");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: text console cell writer testbench
// Drives console commands over the stream port and geometry over the
// register port, predicts cursor, attribute and read cells in a screen
// model held in the tracker class, and compares every status transfer.
// ----------------------------------------------------------------------------

class console_tracker;
	logic [15:0] cells [tcw_pkg::CellCount];
	int unsigned col, row, act_attr, def_attr, cols_reg, rows_reg;
	logic [47:0] pending [$];
	int errors;
	int checked;

	function void init();
		for (int i = 0; i < tcw_pkg::CellCount; i++)
			cells[i] = {tcw_pkg::ResetAttr, tcw_pkg::BlankChar};
		col = 0; row = 0; act_attr = tcw_pkg::ResetAttr; def_attr = tcw_pkg::ResetAttr;
		cols_reg = tcw_pkg::ResetCols; rows_reg = tcw_pkg::ResetRows;
		errors = 0; checked = 0;
	endfunction

	function int unsigned ncols();
		return cols_reg < 1 ? 1 : (cols_reg > tcw_pkg::MaxCols ? tcw_pkg::MaxCols : cols_reg);
	endfunction

	function int unsigned nrows();
		return rows_reg < 1 ? 1 : (rows_reg > tcw_pkg::MaxRows ? tcw_pkg::MaxRows : rows_reg);
	endfunction

	function void set_geometry(int idx, int unsigned v);
		if (idx == tcw_pkg::RegCols) cols_reg = v & 8'hFF;
		else if (idx == tcw_pkg::RegRows) rows_reg = v & 6'h3F;
		if (col > ncols() - 1) col = ncols() - 1;
		if (row > nrows() - 1) row = nrows() - 1;
	endfunction

	function void scroll_screen();
		int unsigned c, r;
		c = ncols(); r = nrows();
		for (int unsigned i = 0; i + c < c * r; i++) cells[i] = cells[i + c];
		for (int unsigned i = (r - 1) * c; i < r * c; i++)
			cells[i] = {act_attr[7:0], tcw_pkg::BlankChar};
		row = r - 1;
	endfunction

	function void print_byte(int unsigned ch);
		int unsigned c;
		c = ncols();
		if (ch < 8'h20 || ch == 8'h7F) begin
			if (ch == 8'h09) col = (col / tcw_pkg::TabStep + 1) * tcw_pkg::TabStep;
			else if (ch == 8'h08) begin
				if (col > 0) col--;
			end else if (ch == 8'h0A) begin
				row++; col = 0;
			end else if (ch == 8'h0D) col = 0;
		end else begin
			cells[row * c + col] = {act_attr[7:0], ch[7:0]};
			col++;
		end
		if (col >= c) begin
			col = 0; row++;
		end
		if (row >= nrows()) scroll_screen();
	endfunction

	// note an accepted command and queue its status
	function void note_command(logic [39:0] d);
		tcw_pkg::opcode_t op;
		int unsigned ch, at, px, py, c, r, cell_w;
		op = tcw_pkg::opcode_t'(d[2:0]); ch = d[10:3]; at = d[18:11];
		px = d[26:19]; py = d[34:27];
		c = ncols(); r = nrows(); cell_w = 0;
		if (px > c - 1) px = c - 1;
		if (py > r - 1) py = r - 1;
		case (op)
			tcw_pkg::OP_PUT_CHAR: print_byte(ch);
			tcw_pkg::OP_SET_POS: begin
				col = px; row = py;
			end
			tcw_pkg::OP_SET_ATTR: act_attr = at;
			tcw_pkg::OP_SET_DEFAULT: def_attr = at;
			tcw_pkg::OP_RESTORE_DEF: act_attr = def_attr;
			tcw_pkg::OP_CLEAR: begin
				for (int unsigned i = 0; i < c * r; i++)
					cells[i] = {at[7:0], tcw_pkg::BlankChar};
				col = 0; row = 0; act_attr = at; def_attr = at;
			end
			tcw_pkg::OP_READ_CELL: cell_w = cells[py * c + px];
			default: ;
		endcase
		pending.push_back({cell_w[15:0], act_attr[7:0], 12'((row * c + col) & 12'hFFF),
			row[4:0], col[6:0]});
	endfunction

	// compare one status transfer with the oldest expectation
	function void check_status(logic [47:0] got);
		logic [47:0] exp_s;
		if (pending.size() == 0) begin
			$display("%0t: unexpected status %h", $time, got);
			errors++;
			return;
		end
		exp_s = pending.pop_front();
		checked++;
		if (got[6:0] !== exp_s[6:0])
			$display("%0t: cursor_col exp %0d got %0d", $time, exp_s[6:0], got[6:0]);
		if (got[11:7] !== exp_s[11:7])
			$display("%0t: cursor_row exp %0d got %0d", $time, exp_s[11:7], got[11:7]);
		if (got[23:12] !== exp_s[23:12])
			$display("%0t: cursor_linear exp %0d got %0d", $time, exp_s[23:12], got[23:12]);
		if (got[31:24] !== exp_s[31:24])
			$display("%0t: current_attr exp %h got %h", $time, exp_s[31:24], got[31:24]);
		if (got[47:32] !== exp_s[47:32])
			$display("%0t: cell_word exp %h got %h", $time, exp_s[47:32], got[47:32]);
		if (got !== exp_s) errors++;
	endfunction
endclass

module tb;
	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	console_tracker trk;
	bit calm;
	int cycles;
	int n_sent;

	text_console_cell_writer_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: worst case is a full scroll on every item with stalls on top
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// take status transfers, stalling now and then
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) trk.check_status(m_axis_tdata);
			@(negedge clk);
			m_axis_tready = calm || ($urandom_range(99) >= 12);
		end
	end

	task automatic reg_write(int idx, int unsigned v);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = 3'(idx * 4); pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		trk.set_geometry(idx, v);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic send(tcw_pkg::opcode_t op, int unsigned ch, int unsigned at,
			int unsigned px, int unsigned py);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 12) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {5'd0, py[7:0], px[7:0], at[7:0], ch[7:0], op};
		do @(posedge clk); while (!s_axis_tready);
		trk.note_command(s_axis_tdata);
		n_sent++;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (trk.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_random(int n);
		int unsigned pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 55)
				send(tcw_pkg::OP_PUT_CHAR, ($urandom_range(9) == 0) ? $urandom_range(31) :
					$urandom_range(255), 0, 0, 0);
			else if (pick < 97) begin
				pick = $urandom_range(6);
				if (pick == 5 && $urandom_range(3) != 0) pick = 6;
				send(tcw_pkg::opcode_t'(pick), $urandom_range(255), $urandom_range(255),
					($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15),
					($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7));
			end else
				send(tcw_pkg::OP_NONE, $urandom_range(255), $urandom_range(255),
					$urandom_range(255), $urandom_range(255));
		end
	endtask

	initial begin
		trk = new();
		trk.init();
		calm = 1'b0;
		n_sent = 0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// small screen so scrolls and wraps come often
		reg_write(tcw_pkg::RegCols, 8);
		reg_write(tcw_pkg::RegRows, 4);

		// directed: every opcode, control codes, extremes
		send(tcw_pkg::OP_READ_CELL, 0, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h41, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'hFF, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h80, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h7F, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h00, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h09, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h09, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h08, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h0D, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h08, 0, 0, 0);
		send(tcw_pkg::OP_SET_ATTR, 0, 8'hFF, 0, 0);
		send(tcw_pkg::OP_SET_POS, 0, 0, 8'hFF, 8'hFF);
		send(tcw_pkg::OP_PUT_CHAR, 8'h7E, 0, 0, 0);
		send(tcw_pkg::OP_PUT_CHAR, 8'h0A, 0, 0, 0);
		send(tcw_pkg::OP_SET_DEFAULT, 0, 8'h5A, 0, 0);
		send(tcw_pkg::OP_RESTORE_DEF, 0, 0, 0, 0);
		send(tcw_pkg::OP_READ_CELL, 0, 0, 8'hFF, 8'hFF);
		send(tcw_pkg::OP_CLEAR, 0, 8'h00, 0, 0);
		send(tcw_pkg::OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send(tcw_pkg::OP_READ_CELL, 0, 0, 3, 2);

		// hold off until every status is back
		drain();

		// random phases across geometries, extremes included
		send_random(100);
		drain();
		reg_write(tcw_pkg::RegCols, 0);
		reg_write(tcw_pkg::RegRows, 0);
		send_random(40);
		drain();
		reg_write(tcw_pkg::RegCols, 255);
		reg_write(tcw_pkg::RegRows, 63);
		send_random(20);
		drain();
		reg_write(tcw_pkg::RegCols, 128);
		reg_write(tcw_pkg::RegRows, 32);
		send_random(20);
		drain();
		reg_write(tcw_pkg::RegCols, 5);
		reg_write(tcw_pkg::RegRows, 3);
		calm = 1'b1;
		send_random(120);
		calm = 1'b0;
		drain();
		reg_write(tcw_pkg::RegCols, 1);
		reg_write(tcw_pkg::RegRows, 1);
		send_random(30);
		drain();
		reg_write(tcw_pkg::RegCols, 13);
		reg_write(tcw_pkg::RegRows, 6);
		send_random(100);
		drain();

		$display("Covered %0d commands, %0d status transfers, over several geometries.",
			n_sent, trk.checked);
		if (trk.errors == 0 && trk.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[sim.f]
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_mult.sv
hdl/text_console_cell_writer_unit.sv
dv/tb.sv
